// ===== sv/vscfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vscfs_pkg
// Shared types and constants for the start code frame splitter.
// ----------------------------------------------------------------------------
package vscfs_pkg;

    localparam int POS_W   = 32;
    localparam int CMP_W   = (POS_W > 32) ? POS_W : 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_STREAM_MODE = 2'd0;
    localparam cfg_idx_t CFG_HEADER_ONLY = 2'd1;
    localparam cfg_idx_t CFG_MAX_LENGTH  = 2'd2;

    typedef logic [1:0] stream_mode_t;
    localparam stream_mode_t MODE_AVC   = 2'd0;
    localparam stream_mode_t MODE_PART2 = 2'd1;
    localparam stream_mode_t MODE_MPV   = 2'd2;

    localparam logic [0:0] KIND_HEADER  = 1'b0;
    localparam logic [0:0] KIND_PICTURE = 1'b1;

    localparam logic [7:0] TALLY_MAX = 8'd255;

    typedef enum logic [2:0] {
        SC_IDLE   = 3'd0,
        SC_ZERO1  = 3'd1,
        SC_ZERO2  = 3'd2,
        SC_ZERO3  = 3'd3,
        SC_PREFIX = 3'd4,
        SC_SLICE  = 3'd5
    } scan_state_t;

    // events raised by the scanner for one byte
    typedef struct packed {
        logic mark_pending;
        logic bump_pending;
        logic mark_header;
        logic mark_picture;
        logic set_short;
    } scan_evt_t;

endpackage
`default_nettype wire

// ===== sv/vscfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vscfs_byte_if / vscfs_frame_if
// Valid/ready channels for stream bytes and frame records.
// ----------------------------------------------------------------------------
interface vscfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface vscfs_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_start;
    logic [31:0] frame_len;
    logic        frame_kind;
    logic        too_long;

    modport source (output valid, output frame_start, output frame_len,
                    output frame_kind, output too_long, input ready);
    modport sink   (input valid, input frame_start, input frame_len,
                    input frame_kind, input too_long, output ready);
endinterface
`default_nettype wire

// ===== sv/video_start_code_frame_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_start_code_frame_splitter
// Scans a compressed video byte stream for start codes and reports frames.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock cycle, sustained, as long as frame records
// are taken. A byte is held in an input register, then classified and folded
// into the frame state once the result register is free, and a closing byte's
// frame record is loaded into the result register in that same update.
// The single result register sets the rate: a byte stalls only while a
// record waits there and the sink holds ready low.
module video_start_code_frame_splitter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  vscfs_pkg::cfg_idx_t         cfg_index,
    input  logic [vscfs_pkg::CFG_W-1:0] cfg_data,
    vscfs_byte_if.sink                  byte_in,
    vscfs_frame_if.source               frame_out
);

    localparam int POS_W = vscfs_pkg::POS_W;
    localparam int CMP_W = vscfs_pkg::CMP_W;

    // configuration
    vscfs_pkg::stream_mode_t stream_mode_reg;
    logic                    header_only_reg;
    logic [31:0]             max_len_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // frame state
    vscfs_pkg::scan_state_t scan_state_reg;
    vscfs_pkg::scan_state_t scan_state_next;
    logic [POS_W-1:0]       byte_position_reg;
    logic [POS_W-1:0]       pending_reg, pending_next;
    logic [POS_W-1:0]       frame_begin_reg, frame_begin_next;
    logic [7:0]             header_tally_reg, header_tally_next;
    logic [7:0]             picture_tally_reg, picture_tally_next;
    logic                   start_known_reg, start_known_next;
    logic                   seeking_end_reg, seeking_end_next;
    logic                   short_seen_reg, short_seen_next;
    logic                   last_kind_reg, last_kind_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] frame_start_reg, frame_start_next;
    logic [31:0] frame_len_reg, frame_len_next;
    logic        frame_kind_reg;
    logic        too_long_reg, too_long_next;
    logic        emit;

    logic                 advance;
    logic                 in_take;
    vscfs_pkg::scan_evt_t evt;

    assign advance       = s1_valid_reg && (!out_valid_reg || frame_out.ready);
    assign byte_in.ready = !s1_valid_reg || advance;
    assign in_take       = byte_in.valid && byte_in.ready;

    assign frame_out.valid       = out_valid_reg;
    assign frame_out.frame_start = frame_start_reg;
    assign frame_out.frame_len   = frame_len_reg;
    assign frame_out.frame_kind  = frame_kind_reg;
    assign frame_out.too_long    = too_long_reg;

    vscfs_scan u_scan
    (
        .state             (scan_state_reg),
        .data_byte         (s1_byte_reg),
        .stream_mode       (stream_mode_reg),
        .header_only       (header_only_reg),
        .seeking_end       (seeking_end_reg),
        .short_header_seen (short_seen_reg),
        .state_next        (scan_state_next),
        .evt               (evt)
    );

    always_comb
    begin
        logic             ended;
        logic [POS_W-1:0] len;

        pending_next       = pending_reg;
        frame_begin_next   = frame_begin_reg;
        header_tally_next  = header_tally_reg;
        picture_tally_next = picture_tally_reg;
        start_known_next   = start_known_reg;
        seeking_end_next   = seeking_end_reg;
        short_seen_next    = short_seen_reg || evt.set_short;
        last_kind_next     = last_kind_reg;
        ended              = 1'b0;

        if (evt.mark_pending)
            pending_next = byte_position_reg;
        else if (evt.bump_pending)
            pending_next = pending_reg + POS_W'(1);

        if (evt.mark_header)
        begin
            last_kind_next = vscfs_pkg::KIND_HEADER;
            if (header_tally_reg != vscfs_pkg::TALLY_MAX)
                header_tally_next = header_tally_reg + 8'd1;
        end
        if (evt.mark_picture)
        begin
            last_kind_next = vscfs_pkg::KIND_PICTURE;
            if (picture_tally_reg != vscfs_pkg::TALLY_MAX)
                picture_tally_next = picture_tally_reg + 8'd1;
        end

        if (header_only_reg && header_tally_next != 8'd0 && picture_tally_next == 8'd1)
        begin
            ended = 1'b1;
        end
        else
        begin
            if (!start_known_next && header_tally_next == 8'd1 && picture_tally_next == 8'd0)
            begin
                frame_begin_next = pending_next;
                start_known_next = 1'b1;
            end
            if (!start_known_next && header_tally_next == 8'd0 && picture_tally_next == 8'd1)
            begin
                frame_begin_next   = pending_next;
                start_known_next   = 1'b1;
                seeking_end_next   = 1'b1;
                picture_tally_next = 8'd0;
            end
            if (!seeking_end_next && header_tally_next != 8'd0 && picture_tally_next == 8'd1)
            begin
                seeking_end_next   = 1'b1;
                header_tally_next  = 8'd0;
                picture_tally_next = 8'd0;
            end
            if (seeking_end_next && (header_tally_next != 8'd0 || picture_tally_next != 8'd0))
            begin
                ended            = 1'b1;
                seeking_end_next = (header_tally_next == 8'd0);
            end
        end

        len              = pending_next - frame_begin_next;
        emit             = ended && start_known_next;
        frame_start_next = 32'(frame_begin_next);
        frame_len_next   = 32'(len);
        too_long_next    = CMP_W'(len) > CMP_W'(max_len_reg);

        if (emit)
        begin
            frame_begin_next   = pending_next;
            picture_tally_next = 8'd0;
            if (last_kind_next == vscfs_pkg::KIND_PICTURE)
            begin
                seeking_end_next  = 1'b1;
                header_tally_next = 8'd0;
            end
            else
            begin
                seeking_end_next  = 1'b0;
                header_tally_next = 8'd1;
                short_seen_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_mode_reg <= vscfs_pkg::MODE_AVC;
            header_only_reg <= 1'b0;
            max_len_reg     <= 32'hFFFF_FFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vscfs_pkg::CFG_STREAM_MODE: stream_mode_reg <= cfg_data[1:0];
                vscfs_pkg::CFG_HEADER_ONLY: header_only_reg <= cfg_data[0];
                vscfs_pkg::CFG_MAX_LENGTH:  max_len_reg <= cfg_data[31:0];
                default:                    header_only_reg <= header_only_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            scan_state_reg    <= vscfs_pkg::SC_IDLE;
            byte_position_reg <= '0;
            pending_reg       <= '0;
            frame_begin_reg   <= '0;
            header_tally_reg  <= '0;
            picture_tally_reg <= '0;
            start_known_reg   <= 1'b0;
            seeking_end_reg   <= 1'b0;
            short_seen_reg    <= 1'b0;
            last_kind_reg     <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg     <= emit;
                scan_state_reg    <= scan_state_next;
                byte_position_reg <= byte_position_reg + POS_W'(1);
                pending_reg       <= pending_next;
                frame_begin_reg   <= frame_begin_next;
                header_tally_reg  <= header_tally_next;
                picture_tally_reg <= picture_tally_next;
                start_known_reg   <= start_known_next;
                seeking_end_reg   <= seeking_end_next;
                short_seen_reg    <= short_seen_next;
                last_kind_reg     <= last_kind_next;
            end
            else if (frame_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_byte_reg <= byte_in.data_byte;
        if (advance && emit)
        begin
            frame_start_reg <= frame_start_next;
            frame_len_reg   <= frame_len_next;
            frame_kind_reg  <= last_kind_next;
            too_long_reg    <= too_long_next;
        end
    end

`ifndef SYNTHESIS
    // the end search only runs once a frame start is known
    assert property (@(posedge clk) disable iff (!rst_n)
        seeking_end_reg |-> start_known_reg)
        else $error("end search without a known frame start");

    // a record only appears after a byte was processed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("frame record without a processed byte");

    // an input request waits only behind a stalled record
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !byte_in.ready) |-> (out_valid_reg && !frame_out.ready))
        else $error("input stalled without output backpressure");
`endif

endmodule
`default_nettype wire

// ===== sv/vscfs_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vscfs_scan
// Start code scanner: next scan state and code classification for one byte.
// ----------------------------------------------------------------------------
module vscfs_scan
(
    input  vscfs_pkg::scan_state_t  state,
    input  logic [7:0]              data_byte,
    input  vscfs_pkg::stream_mode_t stream_mode,
    input  logic                    header_only,
    input  logic                    seeking_end,
    input  logic                    short_header_seen,
    output vscfs_pkg::scan_state_t  state_next,
    output vscfs_pkg::scan_evt_t    evt
);

    logic       is_h264;
    logic       is_mpeg4;
    logic       is_mpeg12;
    logic [4:0] nal_type;
    logic       short_hdr;
    logic       code_header;
    logic       code_picture;

    assign is_h264   = (stream_mode == vscfs_pkg::MODE_AVC);
    assign is_mpeg4  = (stream_mode == vscfs_pkg::MODE_PART2);
    assign is_mpeg12 = (stream_mode == vscfs_pkg::MODE_MPV);
    assign nal_type  = data_byte[4:0];
    assign short_hdr = is_mpeg4 && ((data_byte & 8'hFC) == 8'h80);

    assign code_header =
        (is_h264 && (nal_type == 5'd6 || nal_type == 5'd7 || nal_type == 5'd8)) ||
        (is_mpeg4 && ((data_byte & 8'hF0) <= 8'h20 || data_byte == 8'hB0 ||
                      data_byte == 8'hB2 || data_byte == 8'hB3 ||
                      data_byte == 8'hB5)) ||
        (is_mpeg12 && (data_byte == 8'hB3 || data_byte == 8'hB8));
    assign code_picture = (is_mpeg4 && data_byte == 8'hB6) ||
                          (is_mpeg12 && data_byte == 8'h00);

    always_comb
    begin
        state_next = vscfs_pkg::SC_IDLE;
        unique case (state)
            vscfs_pkg::SC_IDLE:
            begin
                if (data_byte == 8'h00)
                    state_next = vscfs_pkg::SC_ZERO1;
            end
            vscfs_pkg::SC_ZERO1:
            begin
                if (data_byte == 8'h00)
                    state_next = vscfs_pkg::SC_ZERO2;
            end
            vscfs_pkg::SC_ZERO2:
            begin
                priority if (data_byte == 8'h01)
                    state_next = vscfs_pkg::SC_PREFIX;
                else if (short_hdr)
                    state_next = vscfs_pkg::SC_IDLE;
                else if (data_byte == 8'h00)
                    state_next = is_h264 ? vscfs_pkg::SC_ZERO3 : vscfs_pkg::SC_ZERO2;
                else
                    state_next = vscfs_pkg::SC_IDLE;
            end
            vscfs_pkg::SC_ZERO3:
            begin
                priority if (data_byte == 8'h01)
                    state_next = vscfs_pkg::SC_PREFIX;
                else if (data_byte == 8'h00)
                    state_next = vscfs_pkg::SC_ZERO3;
                else
                    state_next = vscfs_pkg::SC_IDLE;
            end
            vscfs_pkg::SC_PREFIX:
            begin
                if (is_h264 && (nal_type == 5'd1 || nal_type == 5'd5))
                    state_next = vscfs_pkg::SC_SLICE;
            end
            vscfs_pkg::SC_SLICE:
            begin
                state_next = vscfs_pkg::SC_IDLE;
            end
            default:
            begin
                state_next = vscfs_pkg::SC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        evt = '0;
        unique case (state)
            vscfs_pkg::SC_IDLE:
            begin
                evt.mark_pending = (data_byte == 8'h00);
            end
            vscfs_pkg::SC_ZERO2:
            begin
                if (data_byte != 8'h01 && short_hdr)
                begin
                    priority if (header_only && !short_header_seen)
                    begin
                        evt.mark_header = 1'b1;
                        evt.set_short   = 1'b1;
                    end
                    else if (!seeking_end || short_header_seen)
                    begin
                        evt.mark_picture = 1'b1;
                        evt.set_short    = 1'b1;
                    end
                    else
                    begin
                        evt.set_short = 1'b0;
                    end
                end
                else if (data_byte == 8'h00 && !is_h264)
                begin
                    evt.bump_pending = 1'b1;
                end
            end
            vscfs_pkg::SC_ZERO3:
            begin
                evt.bump_pending = (data_byte == 8'h00);
            end
            vscfs_pkg::SC_PREFIX:
            begin
                // slice codes are classified on the following byte
                if (!(is_h264 && (nal_type == 5'd1 || nal_type == 5'd5)))
                begin
                    evt.mark_header  = code_header;
                    evt.mark_picture = !code_header && code_picture;
                end
            end
            vscfs_pkg::SC_SLICE:
            begin
                // first_mb_in_slice == 0 starts a new picture
                evt.mark_picture = data_byte[7];
            end
            default:
            begin
                evt = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== tb/video_start_code_frame_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_start_code_frame_splitter_tb
// Self-checking bench for the start code frame splitter.
// ----------------------------------------------------------------------------
// Byte streams are built from start codes of each stream mode with random
// payload, mixed with broken prefixes and zero runs, and fed through the
// byte channel with random gaps. A cycle-free model of the frame state
// predicts each frame record when its closing byte is accepted; records
// are checked in order as the sink takes them. Register settings change
// between phases once the block has drained.
// ----------------------------------------------------------------------------
module video_start_code_frame_splitter_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_BYTES    = 52;
    localparam int FLOOD_HEADERS  = 258;

    localparam vscfs_pkg::stream_mode_t MODE_UNUSED = 2'd3;

    // h.264 nal unit types
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    // mpeg-4 part 2 start code values
    localparam logic [7:0] M4_SYS_MAX = 8'h2F;
    localparam logic [7:0] M4_VOS     = 8'hB0;
    localparam logic [7:0] M4_USER    = 8'hB2;
    localparam logic [7:0] M4_GOV     = 8'hB3;
    localparam logic [7:0] M4_VO      = 8'hB5;
    localparam logic [7:0] M4_VOP     = 8'hB6;
    localparam logic [5:0] SHORT_HDR_TAG = 6'b100000;

    // mpeg-1/2 start code values
    localparam logic [7:0] M2_PIC = 8'h00;
    localparam logic [7:0] M2_SEQ = 8'hB3;
    localparam logic [7:0] M2_GOP = 8'hB8;

    typedef struct packed {
        logic [31:0] frame_start;
        logic [31:0] frame_len;
        logic        frame_kind;
        logic        too_long;
    } frame_rec_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    vscfs_pkg::cfg_idx_t        cfg_index;
    logic [vscfs_pkg::CFG_W-1:0] cfg_data;

    vscfs_byte_if  bytes_in();
    vscfs_frame_if frames();

    video_start_code_frame_splitter u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_in   (bytes_in),
        .frame_out (frames)
    );

    // frame state model
    vscfs_pkg::stream_mode_t cfg_mode;
    logic                    cfg_hdr_only;
    logic [31:0]             cfg_max_len;
    vscfs_pkg::scan_state_t  scan_st;
    logic [31:0]             byte_pos;
    logic [31:0]             code_pos;
    logic [31:0]             frame_beg;
    logic [7:0]              hdr_cnt;
    logic [7:0]              pic_cnt;
    logic                    start_known;
    logic                    seeking_end;
    logic                    short_seen;
    logic                    last_kind;

    frame_rec_t   expected_frames[$];
    logic [7:0]   pending_bytes[$];
    frame_rec_t   next_rec;
    frame_rec_t   want;

    int bytes_queued;
    int bytes_offered;
    int bytes_taken;
    int frames_taken;
    int frames_seen;
    int mismatches;
    int quiet_cycles;
    int src_gap;
    int snk_stall;
    int hold_left;
    int hold_orders;
    int hold_served;
    bit src_idle_on;
    bit snk_idle_on;
    logic nxt_valid;
    logic nxt_ready;

    function automatic void note_header();
        last_kind = vscfs_pkg::KIND_HEADER;
        if (hdr_cnt != vscfs_pkg::TALLY_MAX)
            hdr_cnt++;
    endfunction

    function automatic void note_picture();
        last_kind = vscfs_pkg::KIND_PICTURE;
        if (pic_cnt != vscfs_pkg::TALLY_MAX)
            pic_cnt++;
    endfunction

    function automatic void classify_byte(input logic [7:0] b);
        logic [4:0] nal;
        nal = b[4:0];
        case (scan_st)
            vscfs_pkg::SC_IDLE:
                if (b == 8'h00)
                begin
                    scan_st  = vscfs_pkg::SC_ZERO1;
                    code_pos = byte_pos;
                end
            vscfs_pkg::SC_ZERO1:
                scan_st = (b == 8'h00) ? vscfs_pkg::SC_ZERO2 : vscfs_pkg::SC_IDLE;
            vscfs_pkg::SC_ZERO2:
                if (b == 8'h01)
                    scan_st = vscfs_pkg::SC_PREFIX;
                else if (cfg_mode == vscfs_pkg::MODE_PART2 && b[7:2] == SHORT_HDR_TAG)
                begin
                    scan_st = vscfs_pkg::SC_IDLE;
                    if (cfg_hdr_only && !short_seen)
                    begin
                        note_header();
                        short_seen = 1'b1;
                    end
                    else if (!seeking_end || short_seen)
                    begin
                        note_picture();
                        short_seen = 1'b1;
                    end
                end
                else if (b == 8'h00)
                begin
                    if (cfg_mode == vscfs_pkg::MODE_AVC)
                        scan_st = vscfs_pkg::SC_ZERO3;
                    else
                        code_pos++;
                end
                else
                    scan_st = vscfs_pkg::SC_IDLE;
            vscfs_pkg::SC_ZERO3:
                if (b == 8'h01)
                    scan_st = vscfs_pkg::SC_PREFIX;
                else if (b == 8'h00)
                    code_pos++;
                else
                    scan_st = vscfs_pkg::SC_IDLE;
            vscfs_pkg::SC_PREFIX:
            begin
                scan_st = vscfs_pkg::SC_IDLE;
                if (cfg_mode == vscfs_pkg::MODE_AVC && (nal == NAL_SLICE || nal == NAL_IDR))
                    scan_st = vscfs_pkg::SC_SLICE;
                else if ((cfg_mode == vscfs_pkg::MODE_AVC &&
                          (nal == NAL_SEI || nal == NAL_SPS || nal == NAL_PPS)) ||
                         (cfg_mode == vscfs_pkg::MODE_PART2 &&
                          (b <= M4_SYS_MAX || b == M4_VOS || b == M4_USER ||
                           b == M4_GOV || b == M4_VO)) ||
                         (cfg_mode == vscfs_pkg::MODE_MPV &&
                          (b == M2_SEQ || b == M2_GOP)))
                    note_header();
                else if ((cfg_mode == vscfs_pkg::MODE_PART2 && b == M4_VOP) ||
                         (cfg_mode == vscfs_pkg::MODE_MPV && b == M2_PIC))
                    note_picture();
            end
            vscfs_pkg::SC_SLICE:
            begin
                // first_mb_in_slice == 0 marks a new picture
                if (b[7])
                    note_picture();
                scan_st = vscfs_pkg::SC_IDLE;
            end
            default:
                scan_st = vscfs_pkg::SC_IDLE;
        endcase
    endfunction

    function automatic bit split_byte(input logic [7:0] b, output frame_rec_t rec);
        bit          ended;
        bit          emit;
        logic [31:0] len;
        ended = 1'b0;
        emit  = 1'b0;
        rec   = '0;
        classify_byte(b);
        if (cfg_hdr_only && hdr_cnt >= 8'd1 && pic_cnt == 8'd1)
            ended = 1'b1;
        else
        begin
            if (!start_known && hdr_cnt == 8'd1 && pic_cnt == 8'd0)
            begin
                frame_beg   = code_pos;
                start_known = 1'b1;
            end
            if (!start_known && hdr_cnt == 8'd0 && pic_cnt == 8'd1)
            begin
                frame_beg   = code_pos;
                start_known = 1'b1;
                seeking_end = 1'b1;
                pic_cnt     = 8'd0;
            end
            if (!seeking_end && hdr_cnt > 8'd0 && pic_cnt == 8'd1)
            begin
                seeking_end = 1'b1;
                hdr_cnt     = 8'd0;
                pic_cnt     = 8'd0;
            end
            if (seeking_end && (hdr_cnt > 8'd0 || pic_cnt > 8'd0))
            begin
                ended       = 1'b1;
                seeking_end = (hdr_cnt == 8'd0);
            end
        end
        if (ended && start_known)
        begin
            len = code_pos - frame_beg;
            rec.frame_start = frame_beg;
            rec.frame_len   = len;
            rec.frame_kind  = last_kind;
            rec.too_long    = (len > cfg_max_len);
            emit      = 1'b1;
            frame_beg = code_pos;
            pic_cnt   = 8'd0;
            if (last_kind == vscfs_pkg::KIND_PICTURE)
            begin
                seeking_end = 1'b1;
                hdr_cnt     = 8'd0;
            end
            else
            begin
                seeking_end = 1'b0;
                hdr_cnt     = 8'd1;
                short_seen  = 1'b0;
            end
        end
        byte_pos++;
        return emit;
    endfunction

    // stimulus building
    task automatic put(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic put_prefix();
        put(8'h00);
        put(8'h00);
        put(8'h01);
    endtask

    task automatic put_payload(input int n);
        for (int i = 0; i < n; i++)
            put(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    endtask

    task automatic put_code(input vscfs_pkg::stream_mode_t m);
        int         sel;
        logic [7:0] r;
        logic [7:0] c;
        sel = $urandom_range(0, 9);
        r   = 8'($urandom);
        case (m)
            vscfs_pkg::MODE_AVC:
            begin
                if ($urandom_range(0, 1) == 1)
                    put(8'h00);
                put_prefix();
                if (sel < 5)
                begin
                    put({r[7:5], (sel < 2) ? NAL_IDR : NAL_SLICE});
                    c = 8'($urandom);
                    c[7] = ($urandom_range(0, 3) != 0);
                    put(c);
                end
                else if (sel < 9)
                    put({r[7:5], (sel == 5) ? NAL_SEI : (sel == 6) ? NAL_PPS : NAL_SPS});
                else
                    put(r);
            end
            vscfs_pkg::MODE_PART2:
            begin
                if (sel < 2)
                begin
                    put(8'h00);
                    put(8'h00);
                    put({SHORT_HDR_TAG, r[1:0]});
                end
                else
                begin
                    put_prefix();
                    if (sel < 5)
                        put(M4_VOP);
                    else if (sel < 7)
                    begin
                        c = 8'($urandom_range(0, M4_SYS_MAX));
                        put(c);
                    end
                    else if (sel < 9)
                        put((r[1:0] == 2'd0) ? M4_VOS : (r[1:0] == 2'd1) ? M4_USER :
                            (r[1:0] == 2'd2) ? M4_GOV : M4_VO);
                    else
                        put(r);
                end
            end
            vscfs_pkg::MODE_MPV:
            begin
                put_prefix();
                if (sel < 4)
                    put(M2_PIC);
                else if (sel < 6)
                    put(M2_SEQ);
                else if (sel < 8)
                    put(M2_GOP);
                else
                    put(r);
            end
            default:
            begin
                put_prefix();
                put(r);
            end
        endcase
        put_payload($urandom_range(0, 12));
    endtask

    task automatic put_noise();
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            repeat ($urandom_range(1, 6)) put(8'h00);
        else if (sel == 1)
            repeat ($urandom_range(1, 5)) put(8'($urandom));
        else
        begin
            // prefix cut short
            put(8'h00);
            put(8'h00);
            put(8'($urandom_range(2, 255)));
        end
    endtask

    task automatic write_reg(input vscfs_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            vscfs_pkg::CFG_STREAM_MODE: cfg_mode = val[1:0];
            vscfs_pkg::CFG_HEADER_ONLY: cfg_hdr_only = val[0];
            vscfs_pkg::CFG_MAX_LENGTH:  cfg_max_len = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_regs(input vscfs_pkg::stream_mode_t m, input logic ho,
                            input logic [31:0] max_len);
        write_reg(vscfs_pkg::CFG_STREAM_MODE, {30'd0, m});
        write_reg(vscfs_pkg::CFG_HEADER_ONLY, {31'd0, ho});
        write_reg(vscfs_pkg::CFG_MAX_LENGTH, max_len);
    endtask

    // wait until every queued byte is taken and every record has come out
    task automatic drain();
        while (pending_bytes.size() != 0 || bytes_in.valid || expected_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // byte sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            nxt_valid = bytes_in.valid;
            if (nxt_valid && bytes_taken == bytes_offered)
            begin
                nxt_valid = 1'b0;
                src_gap = src_idle_on ? $urandom_range(0, 4) : 0;
                if ($urandom_range(0, 63) == 0)
                    src_idle_on = !src_idle_on;
            end
            if (!nxt_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_bytes.size() != 0)
                begin
                    bytes_in.data_byte <= pending_bytes.pop_front();
                    bytes_offered++;
                    nxt_valid = 1'b1;
                end
            end
            bytes_in.valid <= nxt_valid;
        end
    end

    // record sink
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_orders != hold_served)
            begin
                hold_served = hold_orders;
                hold_left   = HOLD_CYCLES;
            end
            if (frames_taken != frames_seen)
            begin
                frames_seen = frames_taken;
                snk_stall = snk_idle_on ? $urandom_range(0, 4) : 0;
                if ($urandom_range(0, 15) == 0)
                    snk_idle_on = !snk_idle_on;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (frames.valid && snk_stall > 0)
            begin
                snk_stall--;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            frames.ready <= nxt_ready;
        end
    end

    // predict on each accepted byte, check each record
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bytes_in.valid && bytes_in.ready)
            begin
                if (split_byte(bytes_in.data_byte, next_rec))
                    expected_frames.push_back(next_rec);
                bytes_taken++;
            end
            if (frames.valid && frames.ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("unexpected frame record: start %h length %h",
                           frames.frame_start, frames.frame_len);
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (frames.frame_start !== want.frame_start)
                    begin
                        $error("frame_start expected %h got %h",
                               want.frame_start, frames.frame_start);
                        mismatches++;
                    end
                    if (frames.frame_len !== want.frame_len)
                    begin
                        $error("frame_len expected %h got %h",
                               want.frame_len, frames.frame_len);
                        mismatches++;
                    end
                    if (frames.frame_kind !== want.frame_kind)
                    begin
                        $error("frame_kind expected %b got %b",
                               want.frame_kind, frames.frame_kind);
                        mismatches++;
                    end
                    if (frames.too_long !== want.too_long)
                    begin
                        $error("too_long expected %b got %b",
                               want.too_long, frames.too_long);
                        mismatches++;
                    end
                end
                frames_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (bytes_in.valid && bytes_in.ready) || (frames.valid && frames.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        vscfs_pkg::stream_mode_t m;
        logic                    ho;
        logic [31:0]             max_len;
        int                      sel;
        int                      phase_end;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = vscfs_pkg::CFG_STREAM_MODE;
        cfg_data           = '0;
        bytes_in.valid     = 1'b0;
        bytes_in.data_byte = 8'h00;
        frames.ready       = 1'b0;

        cfg_mode     = vscfs_pkg::MODE_AVC;
        cfg_hdr_only = 1'b0;
        cfg_max_len  = 32'hFFFF_FFFF;
        scan_st      = vscfs_pkg::SC_IDLE;
        byte_pos     = '0;
        code_pos     = '0;
        frame_beg    = '0;
        hdr_cnt      = '0;
        pic_cnt      = '0;
        start_known  = 1'b0;
        seeking_end  = 1'b0;
        short_seen   = 1'b0;
        last_kind    = vscfs_pkg::KIND_HEADER;

        bytes_queued  = 0;
        bytes_offered = 0;
        bytes_taken   = 0;
        frames_taken  = 0;
        frames_seen   = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        src_gap       = 0;
        snk_stall     = 0;
        hold_left     = 0;
        hold_orders   = 0;
        hold_served   = 0;
        src_idle_on   = 1'b1;
        snk_idle_on   = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // h.264 at reset settings: four byte prefix, sps, idr slice,
        // slice continuing the picture, then a new picture closes the frame
        put(8'h00); put(8'h00); put(8'h00); put(8'h01); put({3'b011, NAL_SPS});
        put(8'hFF);
        put_prefix(); put({3'b011, NAL_IDR}); put(8'h88);
        put(8'h7F);
        put_prefix(); put({3'b010, NAL_SLICE}); put(8'h00);
        put_prefix(); put({3'b000, NAL_SLICE}); put(8'h80);
        drain();

        // header run past the tally limit, then a picture and a closing header
        set_regs(vscfs_pkg::MODE_MPV, 1'b0, 32'hFFFF_FFFF);
        repeat (FLOOD_HEADERS)
        begin
            put_prefix();
            put(M2_SEQ);
        end
        put_prefix(); put(M2_PIC); put_payload(3);
        put_prefix(); put(M2_SEQ); put_payload(2);
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph == 6)
                m = MODE_UNUSED;
            else if (ph % 3 == 0)
                m = vscfs_pkg::MODE_AVC;
            else if (ph % 3 == 1)
                m = vscfs_pkg::MODE_PART2;
            else
                m = vscfs_pkg::MODE_MPV;
            ho = ((ph / 2) % 2 == 1);
            sel = $urandom_range(0, 5);
            if (ph == 0 || sel == 0)
                max_len = 32'd0;
            else if (ph == 1 || sel == 1)
                max_len = 32'hFFFF_FFFF;
            else if (sel == 2)
                max_len = $urandom;
            else
                max_len = $urandom_range(4, 60);
            set_regs(m, ho, max_len);

            // long sink stall while the sender keeps going
            if (ph == 3)
                hold_orders++;

            phase_end = bytes_queued + PHASE_BYTES;
            while (bytes_queued < phase_end)
            begin
                if ($urandom_range(0, 99) < 85)
                    put_code(m);
                else
                    put_noise();
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
sv/vscfs_pkg.sv
sv/vscfs_if.sv
sv/vscfs_scan.sv
sv/video_start_code_frame_splitter.sv
tb/video_start_code_frame_splitter_tb.sv
